FILE: hdl/cau_pkg.sv
package cau_pkg;

  // Operand format and derived datapath widths.
  localparam int DW = 32;            // operand and result width
  localparam int FB = 16;            // fractional bits
  localparam int PW = 2 * DW;        // exact product width
  localparam int SW = 2 * DW + 2;    // signed sum of two products, with headroom
  localparam int QB = DW + 1;        // quotient bits kept by the divider
  localparam int RW = PW + 1;        // divider partial remainder width
  localparam int NW = PW + FB + 1;   // scaled dividend width
  localparam int HW = NW - QB;       // dividend bits above the quotient window
  localparam int CW = (HW > RW) ? HW : RW;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_RDIV  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_OVF     = 2'd2
  } status_e;

  // Per-item control and finished non-divide results, carried down the pipe.
  typedef struct packed {
    logic            valid;
    logic            is_div;
    logic            divz;
    logic            neg_re;
    logic            neg_im;
    logic [DW-1:0]   re;
    logic [DW-1:0]   im;
    status_e         status;
  } tag_t;

  // State of one restoring-division lane.
  typedef struct packed {
    logic [RW-1:0] r;
    logic [QB-1:0] lo;
    logic [QB-1:0] q;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic          ovf;
    logic [DW-1:0] val;
  } sat_t;

  // Clamp a sign and magnitude to the signed DW-bit range.
  function automatic sat_t saturate(logic neg, logic [SW-1:0] mag);
    sat_t          s;
    logic [SW-1:0] pmax;
    logic [SW-1:0] nmax;
    logic [SW-1:0] nmag;
    pmax = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    nmax = pmax + SW'(1);
    nmag = ~mag + SW'(1);
    s.ovf = 1'b0;
    if (!neg) begin
      if (mag > pmax) begin
        s.ovf = 1'b1;
        s.val = {1'b0, {(DW - 1){1'b1}}};
      end else begin
        s.val = mag[DW-1:0];
      end
    end else begin
      if (mag > nmax) begin
        s.ovf = 1'b1;
        s.val = {1'b1, {(DW - 1){1'b0}}};
      end else begin
        s.val = nmag[DW-1:0];
      end
    end
    return s;
  endfunction

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l, logic [PW-1:0] d);
    lane_t         s;
    logic [RW-1:0] t;
    logic [RW-1:0] dx;
    logic          qbit;
    t  = {l.r[RW-2:0], l.lo[QB-1]};
    dx = {1'b0, d};
    qbit = (t >= dx);
    s.r   = qbit ? (t - dx) : t;
    s.lo  = {l.lo[QB-2:0], 1'b0};
    s.q   = {l.q[QB-2:0], qbit};
    s.ovf = l.ovf;
    return s;
  endfunction

endpackage

FILE: hdl/complex_arithmetic_unit.sv
// Channel | Direction | Signals
// --------+-----------+--------------------------------------------------
// in      | input     | in_valid_i, in_ready_o, cmd_i, a_re_i, a_im_i,
//         |           | b_re_i, b_im_i
// out     | output    | out_valid_o, out_ready_i, res_re_o, res_im_o, status_o
//
// One transaction is accepted per cycle unless the output stalls. Each passes through one
// multiply stage, one combine stage, one sign and magnitude stage, one rounding and divider
// setup stage, 33 restoring-division stages, and the output stage.
// Every command runs the full pipeline, so results leave in order.
// Reset clears only the valid bits. A stalled output freezes the whole pipe,
// so nothing is dropped or repeated.
module complex_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    cmd_i,
  input  logic signed [cau_pkg::DW-1:0] a_re_i,
  input  logic signed [cau_pkg::DW-1:0] a_im_i,
  input  logic signed [cau_pkg::DW-1:0] b_re_i,
  input  logic signed [cau_pkg::DW-1:0] b_im_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [cau_pkg::DW-1:0] res_re_o,
  output logic signed [cau_pkg::DW-1:0] res_im_o,
  output logic [1:0]                    status_o
);
  import cau_pkg::*;

  localparam logic [SW-1:0] RND = (FB > 0) ? (SW'(1) << (FB - 1)) : '0;

  // The pipe advances whenever the output register is empty or being drained.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage A: all six products straight from the operands.
  logic                 va_q;
  logic [2:0]           cmd_a_q;
  logic signed [DW-1:0] ar_a_q, ai_a_q, br_a_q, bim_a_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_a_q <= cmd_i;
      ar_a_q  <= a_re_i;
      ai_a_q  <= a_im_i;
      br_a_q  <= b_re_i;
      bim_a_q <= b_im_i;
      p_rr_q  <= a_re_i * b_re_i;
      p_ii_q  <= a_im_i * b_im_i;
      p_ri_q  <= a_re_i * b_im_i;
      p_ir_q  <= a_im_i * b_re_i;
      p_bb_q  <= b_re_i * b_re_i;
      p_cc_q  <= b_im_i * b_im_i;
    end
  end

  // Stage B: form the exact signed numerators and the divisor per command.
  logic signed [SW-1:0] s_re_d, s_im_d;
  logic [PW-1:0]        den_b_d;
  logic                 shift_b_d, is_div_b_d, divz_b_d;
  logic [DW:0]          br_abs;

  always_comb begin
    br_abs     = br_a_q[DW-1] ? (~{1'b1, br_a_q} + (DW+1)'(1)) : {1'b0, br_a_q};
    s_re_d     = '0;
    s_im_d     = '0;
    den_b_d    = '0;
    shift_b_d  = 1'b0;
    is_div_b_d = 1'b0;
    divz_b_d   = 1'b0;
    unique case (cmd_a_q)
      CMD_ADD: begin
        s_re_d = SW'(ar_a_q) + SW'(br_a_q);
        s_im_d = SW'(ai_a_q) + SW'(bim_a_q);
      end
      CMD_SUB: begin
        s_re_d = SW'(ar_a_q) - SW'(br_a_q);
        s_im_d = SW'(ai_a_q) - SW'(bim_a_q);
      end
      CMD_MUL: begin
        s_re_d    = SW'(p_rr_q) - SW'(p_ii_q);
        s_im_d    = SW'(p_ri_q) + SW'(p_ir_q);
        shift_b_d = 1'b1;
      end
      CMD_DIV: begin
        s_re_d     = SW'(p_rr_q) + SW'(p_ii_q);
        s_im_d     = SW'(p_ir_q) - SW'(p_ri_q);
        den_b_d    = p_bb_q + p_cc_q;
        is_div_b_d = 1'b1;
        divz_b_d   = (den_b_d == '0);
      end
      CMD_SCALE: begin
        s_re_d    = SW'(p_rr_q);
        s_im_d    = SW'(p_ir_q);
        shift_b_d = 1'b1;
      end
      CMD_RDIV: begin
        // The divisor's sign is folded into the numerator.
        s_re_d     = br_a_q[DW-1] ? -SW'(ar_a_q) : SW'(ar_a_q);
        s_im_d     = br_a_q[DW-1] ? -SW'(ai_a_q) : SW'(ai_a_q);
        den_b_d    = PW'(br_abs);
        is_div_b_d = 1'b1;
        divz_b_d   = (br_a_q == '0);
      end
      default: begin
      end
    endcase
  end

  logic                 vb_q;
  logic signed [SW-1:0] s_re_q, s_im_q;
  logic [PW-1:0]        den_b_q;
  logic                 shift_b_q, is_div_b_q, divz_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_re_q     <= s_re_d;
      s_im_q     <= s_im_d;
      den_b_q    <= den_b_d;
      shift_b_q  <= shift_b_d;
      is_div_b_q <= is_div_b_d;
      divz_b_q   <= divz_b_d;
    end
  end

  // Stage C: split into sign and magnitude.
  logic [SW-1:0] su_re, su_im;
  assign su_re = s_re_q;
  assign su_im = s_im_q;

  logic          vc_q;
  logic          neg_re_q, neg_im_q;
  logic [SW-1:0] mag_re_q, mag_im_q;
  logic [PW-1:0] den_c_q;
  logic          shift_c_q, is_div_c_q, divz_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_re_q   <= su_re[SW-1];
      neg_im_q   <= su_im[SW-1];
      mag_re_q   <= su_re[SW-1] ? (~su_re + SW'(1)) : su_re;
      mag_im_q   <= su_im[SW-1] ? (~su_im + SW'(1)) : su_im;
      den_c_q    <= den_b_q;
      shift_c_q  <= shift_b_q;
      is_div_c_q <= is_div_b_q;
      divz_c_q   <= divz_b_q;
    end
  end

  // Stage D: round and saturate the non-divide results, and set up the
  // divider with the scaled dividend and the quotient overflow check.
  logic [SW-1:0] rnd_re, rnd_im;
  sat_t          sat_re_d, sat_im_d;
  tag_t          tag_d;
  lane_t         lane_re_d, lane_im_d;
  logic [NW-1:0] nd_re, nd_im;
  logic [HW-1:0] hi_re, hi_im;

  always_comb begin
    rnd_re   = shift_c_q ? ((mag_re_q + RND) >> FB) : mag_re_q;
    rnd_im   = shift_c_q ? ((mag_im_q + RND) >> FB) : mag_im_q;
    sat_re_d = saturate(neg_re_q, rnd_re);
    sat_im_d = saturate(neg_im_q, rnd_im);

    tag_d.valid  = vc_q;
    tag_d.is_div = is_div_c_q;
    tag_d.divz   = divz_c_q;
    tag_d.neg_re = neg_re_q;
    tag_d.neg_im = neg_im_q;
    tag_d.re     = sat_re_d.val;
    tag_d.im     = sat_im_d.val;
    tag_d.status = (sat_re_d.ovf || sat_im_d.ovf) ? ST_OVF : ST_OK;

    nd_re = {mag_re_q[PW-1:0], {(FB + 1){1'b0}}};
    nd_im = {mag_im_q[PW-1:0], {(FB + 1){1'b0}}};
    hi_re = nd_re[NW-1:QB];
    hi_im = nd_im[NW-1:QB];

    lane_re_d.r   = RW'(hi_re);
    lane_re_d.lo  = nd_re[QB-1:0];
    lane_re_d.q   = '0;
    lane_re_d.ovf = (CW'(hi_re) >= CW'(den_c_q));
    lane_im_d.r   = RW'(hi_im);
    lane_im_d.lo  = nd_im[QB-1:0];
    lane_im_d.q   = '0;
    lane_im_d.ovf = (CW'(hi_im) >= CW'(den_c_q));
  end

  logic          vd_q;
  tag_t          tag_dq;
  tag_t          tag_div;
  logic [PW-1:0] den_dq;
  lane_t         lane_re_q, lane_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= tag_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_dq    <= tag_d;
      den_dq    <= den_c_q;
      lane_re_q <= lane_re_d;
      lane_im_q <= lane_im_d;
    end
  end

  // The divider sees the reset-cleared valid bit with the carried fields.
  always_comb begin
    tag_div       = tag_dq;
    tag_div.valid = vd_q;
  end

  // Restoring divider, one quotient bit per stage.
  tag_t  tag_e;
  lane_t q_re, q_im;

  cau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (tag_div),
    .den_i  (den_dq),
    .re_i   (lane_re_q),
    .im_i   (lane_im_q),
    .tag_o  (tag_e),
    .re_o   (q_re),
    .im_o   (q_im)
  );

  // Final stage: round the quotients and pick the result.
  sat_t          fin_re, fin_im;
  logic [SW-1:0] qm_re, qm_im;
  logic [DW-1:0] res_re_d, res_im_d;
  status_e       status_d;

  always_comb begin
    qm_re  = (SW'(q_re.q) + SW'(1)) >> 1;
    qm_im  = (SW'(q_im.q) + SW'(1)) >> 1;
    fin_re = saturate(tag_e.neg_re, qm_re);
    fin_im = saturate(tag_e.neg_im, qm_im);
    if (q_re.ovf) begin
      fin_re.ovf = 1'b1;
      fin_re.val = tag_e.neg_re ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    end
    if (q_im.ovf) begin
      fin_im.ovf = 1'b1;
      fin_im.val = tag_e.neg_im ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    end

    if (!tag_e.is_div) begin
      res_re_d = tag_e.re;
      res_im_d = tag_e.im;
      status_d = tag_e.status;
    end else if (tag_e.divz) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIVZERO;
    end else begin
      res_re_d = fin_re.val;
      res_im_d = fin_im.val;
      status_d = (fin_re.ovf || fin_im.ovf) ? ST_OVF : ST_OK;
    end
  end

  logic [DW-1:0] res_re_q, res_im_q;
  status_e       status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tag_e.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign status_o    = status_q;

  // A zero divisor always yields a zero result.
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_DIVZERO) |-> (res_re_q == '0) && (res_im_q == '0))
    else $error("divide-by-zero transaction with a nonzero result");

  // An overflow status implies at least one part sits at a bound.
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_OVF) |->
      (res_re_q == {1'b0, {(DW - 1){1'b1}}}) || (res_re_q == {1'b1, {(DW - 1){1'b0}}}) ||
      (res_im_q == {1'b0, {(DW - 1){1'b1}}}) || (res_im_q == {1'b1, {(DW - 1){1'b0}}}))
    else $error("overflow status without a saturated part");

  // While the output stalls, the divider's last stage holds its transaction.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(tag_e.valid) && $stable(q_re.q) && $stable(q_im.q))
    else $error("pipeline moved during an output stall");

endmodule

FILE: hdl/cau_div.sv
module cau_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  cau_pkg::tag_t          tag_i,
  input  logic [cau_pkg::PW-1:0] den_i,
  input  cau_pkg::lane_t         re_i,
  input  cau_pkg::lane_t         im_i,
  output cau_pkg::tag_t          tag_o,
  output cau_pkg::lane_t         re_o,
  output cau_pkg::lane_t         im_o
);
  import cau_pkg::*;

  // One quotient bit per stage, both lanes share the divisor.
  // The valid bit of each stage lives in its own reset register.
  logic          v_q   [QB];
  tag_t          tag_q [QB];
  logic [PW-1:0] den_q [QB];
  lane_t         re_q  [QB];
  lane_t         im_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          v_in;
    tag_t          tag_in;
    logic [PW-1:0] den_in;
    lane_t         re_in;
    lane_t         im_in;

    if (k == 0) begin : g_first
      assign v_in   = tag_i.valid;
      assign tag_in = tag_i;
      assign den_in = den_i;
      assign re_in  = re_i;
      assign im_in  = im_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign tag_in = tag_q[k-1];
      assign den_in = den_q[k-1];
      assign re_in  = re_q[k-1];
      assign im_in  = im_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= tag_in;
        den_q[k] <= den_in;
        re_q[k]  <= div_step(re_in, den_in);
        im_q[k]  <= div_step(im_in, den_in);
      end
    end
  end

  always_comb begin
    tag_o       = tag_q[QB-1];
    tag_o.valid = v_q[QB-1];
  end

  assign re_o = re_q[QB-1];
  assign im_o = im_q[QB-1];

endmodule
